>>> src/easc_pkg.sv
package easc_pkg;

    // Packet layout
    localparam int unsigned C_DATA_BYTES = 14;  // data bytes after each header
    localparam int unsigned C_SCALE_MAX  = 14;  // largest legal scale

    // Command queue depth
    localparam int unsigned C_QUEUE_DEPTH = 4;
    localparam int unsigned C_QUEUE_AW    = $clog2(C_QUEUE_DEPTH);

    // One queued command from the classifier to the decode engine
    typedef struct packed {
        logic       has_data;   // data byte: two samples
        logic [7:0] data_byte;
        logic [1:0] ptype;      // packet type from header
        logic [3:0] scale;      // scale from header
        logic       tail_err;   // error result follows (or is the whole command)
        logic       clear;      // clear envelope/delta after this command
    } t_cmd;

endpackage

>>> src/easc_front.sv
module easc_front
    import easc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_packet_byte,
    input  logic       i_end_of_sound,
    input  logic       i_full,
    output logic       o_in_stall,
    output logic       o_push,
    output t_cmd       o_push_cmd
);

    logic [3:0] r_pos, n_pos;
    logic [1:0] r_ptype, n_ptype;
    logic [3:0] r_scale, n_scale;
    logic       r_failed, n_failed;
    logic       accept;
    logic [3:0] scale_in;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;
    assign scale_in   = i_packet_byte[3:0];

    // Classify each transfer and queue the work it causes
    always_comb begin
        n_pos      = r_pos;
        n_ptype    = r_ptype;
        n_scale    = r_scale;
        n_failed   = r_failed;
        o_push     = 1'b0;
        o_push_cmd = '0;
        if (accept) begin
            if (!r_failed) begin
                if (r_pos == 4'd0) begin
                    if (scale_in > 4'(C_SCALE_MAX)) begin
                        // bad scale: lone error result
                        n_failed            = 1'b1;
                        o_push              = 1'b1;
                        o_push_cmd.tail_err = 1'b1;
                        o_push_cmd.clear    = 1'b1;
                    end else begin
                        n_ptype = i_packet_byte[5:4];
                        n_scale = scale_in;
                        n_pos   = 4'd1;
                        // sound ends right after a header
                        if (i_end_of_sound) begin
                            o_push              = 1'b1;
                            o_push_cmd.tail_err = 1'b1;
                            o_push_cmd.clear    = 1'b1;
                        end
                    end
                end else begin
                    n_pos = (r_pos >= 4'(C_DATA_BYTES)) ? 4'd0 : r_pos + 4'd1;
                    o_push               = 1'b1;
                    o_push_cmd.has_data  = 1'b1;
                    o_push_cmd.data_byte = i_packet_byte;
                    o_push_cmd.ptype     = r_ptype;
                    o_push_cmd.scale     = r_scale;
                    o_push_cmd.tail_err  = i_end_of_sound && (n_pos != 4'd0);
                    o_push_cmd.clear     = i_end_of_sound;
                end
            end
            // end of sound returns everything to idle
            if (i_end_of_sound) begin
                n_pos    = 4'd0;
                n_ptype  = 2'd0;
                n_scale  = 4'd0;
                n_failed = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 4'd0;
            r_ptype  <= 2'd0;
            r_scale  <= 4'd0;
            r_failed <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_ptype  <= n_ptype;
            r_scale  <= n_scale;
            r_failed <= n_failed;
        end
    end

endmodule

>>> src/easc_cmd_fifo.sv
module easc_cmd_fifo
    import easc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_full,
    output logic o_empty
);

    t_cmd                  r_mem [C_QUEUE_DEPTH];
    logic [C_QUEUE_AW-1:0] r_wr_ptr;
    logic [C_QUEUE_AW-1:0] r_rd_ptr;
    logic [C_QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (C_QUEUE_AW+1)'(C_QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> src/easc_back.sv
module easc_back
    import easc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_head,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_sample,
    output logic               o_error,
    output logic               o_last_of_item
);

    typedef enum logic [2:0] {
        PH_LO  = 3'b001,
        PH_HI  = 3'b010,
        PH_ERR = 3'b100
    } t_phase;

    t_phase             r_phase, n_phase, cur_phase;
    logic signed [31:0] r_env, n_env;
    logic signed [31:0] r_delta, n_delta;
    logic               r_out_valid;
    logic signed [15:0] r_sample, n_sample;
    logic               r_error, n_error;
    logic               r_last, n_last;
    logic               advance;

    logic [3:0]         nib;
    logic signed [16:0] prod;
    logic signed [16:0] bias;
    logic signed [16:0] raster17;
    logic signed [31:0] raster;
    logic signed [31:0] env_a, delta_a, env_b, delta_b, e3, t3, out_env;

    // Signed divisions by powers of two, truncating toward zero
    function automatic logic signed [31:0] f_div8(input logic signed [31:0] x);
        logic signed [31:0] s;
        s = x + (x[31] ? 32'sd7 : 32'sd0);
        return s >>> 3;
    endfunction

    function automatic logic signed [31:0] f_div16(input logic signed [31:0] x);
        logic signed [31:0] s;
        s = x + (x[31] ? 32'sd15 : 32'sd0);
        return s >>> 4;
    endfunction

    function automatic logic signed [15:0] f_clamp16(input logic signed [31:0] x);
        logic signed [15:0] r;
        if (x > 32'sd32767) begin
            r = 16'sh7fff;
        end else if (x < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = x[15:0];
        end
        return r;
    endfunction

    assign advance   = !i_empty && (!r_out_valid || !i_out_stall);
    // a command with no data byte goes straight to its error result
    assign cur_phase = (r_phase == PH_LO && !i_head.has_data) ? PH_ERR : r_phase;

    // Nibble scaling: nibble*4096 / 2^scale
    always_comb begin
        nib      = (cur_phase == PH_HI) ? i_head.data_byte[7:4] : i_head.data_byte[3:0];
        prod     = {{1{nib[3]}}, nib, 12'd0};
        bias     = (17'sd1 <<< i_head.scale) - 17'sd1;
        raster17 = (prod + (prod[16] ? bias : 17'sd0)) >>> i_head.scale;
        raster   = 32'(raster17);
    end

    // Envelope/delta recurrence for one nibble
    always_comb begin
        env_a   = r_env;
        delta_a = r_delta;
        env_b   = r_env;
        delta_b = r_delta;
        e3      = r_env + (r_env <<< 1);
        t3      = '0;
        out_env = r_env;
        case (i_head.ptype)
            2'd0: begin
                env_b   = raster;
                delta_b = '0;
                out_env = raster;
            end
            2'd1: begin
                delta_b = -raster;
                env_a   = r_env + raster;
                out_env = env_a;
                env_b   = env_a - f_div16(env_a);
            end
            2'd2: begin
                delta_a = r_delta - raster;
                env_a   = r_env - delta_a;
                delta_b = delta_a - f_div8(delta_a);
                out_env = env_a;
                env_b   = env_a - f_div8(env_a);
            end
            default: begin
                delta_b = r_delta - raster + f_div8(e3);
                t3      = r_env - delta_b;
                env_b   = t3 - f_div8(t3);
                out_env = env_b;
            end
        endcase
    end

    // Step through the head command, one result per cycle while the queue holds a command and the output is not stalled
    always_comb begin
        n_phase  = r_phase;
        n_env    = r_env;
        n_delta  = r_delta;
        n_sample = r_sample;
        n_error  = r_error;
        n_last   = r_last;
        o_pop    = 1'b0;
        if (advance) begin
            unique case (cur_phase)
                PH_LO: begin
                    n_env    = env_b;
                    n_delta  = delta_b;
                    n_sample = f_clamp16(out_env);
                    n_error  = 1'b0;
                    n_last   = 1'b0;
                    n_phase  = PH_HI;
                end
                PH_HI: begin
                    n_env    = env_b;
                    n_delta  = delta_b;
                    n_sample = f_clamp16(out_env);
                    n_error  = 1'b0;
                    n_last   = !i_head.tail_err;
                    if (i_head.tail_err) begin
                        n_phase = PH_ERR;
                    end else begin
                        o_pop   = 1'b1;
                        n_phase = PH_LO;
                        if (i_head.clear) begin
                            n_env   = '0;
                            n_delta = '0;
                        end
                    end
                end
                PH_ERR: begin
                    n_sample = '0;
                    n_error  = 1'b1;
                    n_last   = 1'b1;
                    o_pop    = 1'b1;
                    n_phase  = PH_LO;
                    if (i_head.clear) begin
                        n_env   = '0;
                        n_delta = '0;
                    end
                end
                default: begin
                    n_phase = PH_LO;
                end
            endcase
        end
    end

    // Control and recurrence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LO;
            r_env       <= '0;
            r_delta     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_env   <= n_env;
            r_delta <= n_delta;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_error  <= n_error;
        r_last   <= n_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample       = r_sample;
    assign o_error        = r_error;
    assign o_last_of_item = r_last;

endmodule

>>> src/easc_packet_sound_decoder.sv
// Packet sound decoder: takes a compressed sound one byte per transfer, in packets of
// one header byte and 14 data bytes, and returns one 16-bit sample per data nibble (low
// nibble first), an error result on a bad scale or on a sound that ends off a packet
// boundary, and last_of_item on the final result of each byte. Bytes are classified
// combinationally and queued in a 4-entry command queue; the decode engine then
// produces the results in order (two per data byte, one per error), and a good header
// byte gives no result unless the sound ends on it. The envelope/delta recurrence for
// a nibble is combinational.
module easc_packet_sound_decoder
    import easc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_packet_byte,
    input  logic               i_end_of_sound,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_sample,
    output logic               o_error,
    output logic               o_last_of_item
);

    logic push;
    t_cmd push_cmd;
    logic pop;
    t_cmd head;
    logic full;
    logic empty;

    // Byte classifier
    easc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_packet_byte  (i_packet_byte),
        .i_end_of_sound (i_end_of_sound),
        .i_full         (full),
        .o_in_stall     (o_in_stall),
        .o_push         (push),
        .o_push_cmd     (push_cmd)
    );

    // Command queue
    easc_cmd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_head     (head),
        .o_full     (full),
        .o_empty    (empty)
    );

    // Decode engine
    easc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample       (o_sample),
        .o_error        (o_error),
        .o_last_of_item (o_last_of_item)
    );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

import easc_pkg::*;

// Recurrence selected by bits 5:4 of a packet header
typedef enum logic [1:0] {
    PKT_DIRECT  = 2'd0,
    PKT_DECAY   = 2'd1,
    PKT_DAMPED  = 2'd2,
    PKT_PREDICT = 2'd3
} t_pkt_kind;

// Scale code that marks a broken header
localparam logic [3:0] C_BAD_SCALE = 4'(C_SCALE_MAX + 1);

typedef struct {
    logic signed [15:0] sample;
    logic               err;
    logic               last;
} t_sound_result;

// Tracks the decoder state byte by byte and holds the samples still owed
class sample_scoreboard;
    t_sound_result due_samples[$];
    int unsigned   mismatches;
    int unsigned   live_bytes;   // bytes that were not ignored after a failure

    logic [3:0] pos;             // 0: header next, 1..14: data byte index
    t_pkt_kind  ptype;
    logic [3:0] shift;
    int         envl;
    int         dlt;
    bit         failed;

    function new();
        mismatches = 0;
        live_bytes = 0;
        clear_state();
    endfunction

    function void clear_state();
        pos    = '0;
        ptype  = PKT_DIRECT;
        shift  = '0;
        envl   = 0;
        dlt    = 0;
        failed = 1'b0;
    endfunction

    function int pending();
        return due_samples.size();
    endfunction

    // Append one owed result at the tail of the queue
    function void owe(logic signed [15:0] smp, logic err);
        t_sound_result r;
        r.sample = smp;
        r.err    = err;
        r.last   = 1'b0;
        due_samples.insert(due_samples.size(), r);
    endfunction

    function logic signed [15:0] sat16(int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // One nibble through the recurrence of the current packet type
    function logic signed [15:0] nibble_to_sample(logic [3:0] nib);
        int n;
        int raster;
        int t;
        logic signed [15:0] smp;
        n = nib[3] ? int'(nib) - 16 : int'(nib);
        raster = (n * 4096) / (1 << shift);
        case (ptype)
            PKT_DIRECT: begin
                envl = raster;
                dlt  = 0;
                smp  = sat16(envl);
            end
            PKT_DECAY: begin
                dlt  = -raster;
                envl = envl - dlt;
                smp  = sat16(envl);
                envl = envl - envl / 16;
            end
            PKT_DAMPED: begin
                dlt  = dlt - raster;
                envl = envl - dlt;
                dlt  = dlt - dlt / 8;
                smp  = sat16(envl);
                envl = envl - envl / 8;
            end
            default: begin
                dlt  = dlt - raster;
                dlt  = dlt + (envl * 3) / 8;
                t    = envl - dlt;
                envl = t - t / 8;
                smp  = sat16(envl);
            end
        endcase
        return smp;
    endfunction

    // Accepted input transfer: queue the results it should cause
    function void take_byte(logic [7:0] b, logic eos);
        int count;
        count = 0;
        if (!failed) begin
            live_bytes++;
            if (pos == 0) begin
                if (b[3:0] > C_SCALE_MAX) begin
                    failed = 1'b1;
                    owe(16'sd0, 1'b1);
                    count++;
                end else begin
                    ptype = t_pkt_kind'(b[5:4]);
                    shift = b[3:0];
                    pos   = 4'd1;
                end
            end else begin
                owe(nibble_to_sample(b[3:0]), 1'b0);
                owe(nibble_to_sample(b[7:4]), 1'b0);
                count += 2;
                pos = (pos >= C_DATA_BYTES) ? 4'd0 : pos + 4'd1;
            end
            // sound ends off a packet boundary
            if (eos && !failed && pos != 0) begin
                failed = 1'b1;
                owe(16'sd0, 1'b1);
                count++;
            end
        end
        if (count > 0)
            due_samples[due_samples.size() - 1].last = 1'b1;
        if (eos)
            clear_state();
    endfunction

    function void flag(string msg);
        mismatches++;
        $error("%s", msg);
    endfunction

    // Accepted output transfer: compare with the oldest owed result
    function void match_result(logic signed [15:0] sample, logic err, logic last);
        t_sound_result want;
        if (due_samples.size() == 0) begin
            flag($sformatf("unexpected result: sample %0d, error %0b, last_of_item %0b",
                           sample, err, last));
            return;
        end
        want = due_samples.pop_front();
        if (sample !== want.sample)
            flag($sformatf("sample: expected %0d, actual %0d", want.sample, sample));
        if (err !== want.err)
            flag($sformatf("error: expected %0b, actual %0b", want.err, err));
        if (last !== want.last)
            flag($sformatf("last_of_item: expected %0b, actual %0b", want.last, last));
    endfunction
endclass

module tb_top;

    localparam int unsigned C_TARGET_ITEMS = 360;
    localparam int unsigned C_IDLE_LIMIT   = 1000;
    localparam int unsigned C_TAIL_CYCLES  = 40;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [7:0]         i_packet_byte;
    logic               i_end_of_sound;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [15:0] o_sample;
    logic               o_error;
    logic               o_last_of_item;

    sample_scoreboard sb;
    bit               hurry;        // both sides skip idling while set
    int unsigned      idle_cycles;
    int unsigned      sound_no;
    int unsigned      kind;
    int unsigned      full_packets;

    easc_packet_sound_decoder DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_packet_byte  (i_packet_byte),
        .i_end_of_sound (i_end_of_sound),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample       (o_sample),
        .o_error        (o_error),
        .o_last_of_item (o_last_of_item)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Transfer monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.take_byte(i_packet_byte, i_end_of_sound);
            if (o_out_valid && !i_out_stall)
                sb.match_result(o_sample, o_error, o_last_of_item);
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= C_IDLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic int pick_wait();
        if (hurry || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [7:0] rand_data();
        case ($urandom_range(0, 7))
            0:       return 8'h77;
            1:       return 8'h88;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] good_header();
        logic [3:0] sc;
        case ($urandom_range(0, 3))
            0:       sc = 4'd0;
            1:       sc = 4'(C_SCALE_MAX);
            default: sc = 4'($urandom_range(0, C_SCALE_MAX));
        endcase
        return {2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), sc};
    endfunction

    // One input transfer after a random gap
    task automatic send_item(input logic [7:0] b, input logic eos);
        int n;
        n = pick_wait();
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_packet_byte  <= b;
        i_end_of_sound <= eos;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Header plus data_len random data bytes; end_it marks the last byte
    task automatic send_packet(input logic [7:0] hdr, input int data_len, input bit end_it);
        send_item(hdr, end_it && data_len == 0);
        for (int k = 1; k <= data_len; k++)
            send_item(rand_data(), end_it && k == data_len);
    endtask

    // Sender holds off until every owed result has come out
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Result side: random stall before each transfer
    task automatic run_sink();
        int n;
        forever begin
            n = pick_wait();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    endtask

    initial begin
        sb             = new();
        hurry          = 1'b0;
        idle_cycles    = 0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_packet_byte  = '0;
        i_end_of_sound = 1'b0;
        i_out_stall    = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            run_sink();
        join_none

        // finest scale, predictor type, nibble extremes, sound cut mid-packet
        send_item({2'b00, PKT_PREDICT, 4'(C_SCALE_MAX)}, 1'b0);
        send_item(8'h87, 1'b0);
        send_item(8'h78, 1'b1);
        // bad scale: one error, then bytes ignored to the end of the sound
        send_item({4'h0, C_BAD_SCALE}, 1'b0);
        send_item(8'h12, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h55, 1'b1);
        // bad scale on the final byte gives a single error
        send_item({2'b11, PKT_DIRECT, C_BAD_SCALE}, 1'b1);
        // sound made of a header only
        send_item({2'b00, PKT_DIRECT, 4'd0}, 1'b1);
        // whole packet at scale 0 with full-swing nibbles, ends on the boundary
        send_item({2'b11, PKT_DAMPED, 4'd0}, 1'b0);
        for (int k = 1; k <= C_DATA_BYTES; k++)
            send_item((k % 2) ? 8'h77 : 8'h88, k == C_DATA_BYTES);
        hold_until_drained();

        // random sounds: mostly well formed, some cut short or with a bad scale
        sound_no = 0;
        while (sb.live_bytes < C_TARGET_ITEMS) begin
            hurry        = ($urandom_range(0, 3) == 0);
            kind         = $urandom_range(0, 9);
            full_packets = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 4) : 1;
            if (kind < 7) begin
                for (int p = 1; p <= full_packets; p++)
                    send_packet(good_header(), C_DATA_BYTES, p == full_packets);
            end else begin
                if ($urandom_range(0, 1) == 1)
                    send_packet(good_header(), C_DATA_BYTES, 1'b0);
                if (kind == 7)
                    send_packet(good_header(), $urandom_range(0, C_DATA_BYTES - 1), 1'b1);
                else
                    send_packet({4'($urandom_range(0, 15)), C_BAD_SCALE},
                                $urandom_range(0, 3), 1'b1);
            end
            sound_no++;
            if (sound_no % 8 == 0)
                hold_until_drained();
        end

        // drain, then watch a little longer for stray results
        hurry = 1'b1;
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (C_TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
src/easc_pkg.sv
src/easc_front.sv
src/easc_cmd_fifo.sv
src/easc_back.sv
src/easc_packet_sound_decoder.sv
tb/sv/tb_top.sv
